### sv/lrts_pkg.sv
// Shared types and constants for the longest-remaining-time scheduler.
`default_nettype none
package lrts_pkg;
  localparam int PROCS = 16;
  localparam int SW = $clog2(PROCS);
  localparam int CW = $clog2(PROCS + 1);
  localparam logic [23:0] TIME_MAX = 24'hFFFFFF;
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic load;
    logic scan_clr;
    logic scan_step;
    logic update;
    logic [SW-1:0] scan_idx;
  } lrts_cmd_t;

  typedef struct packed {
    logic all_fin;
  } lrts_sts_t;

  typedef struct packed {
    logic [23:0] slot_start;
    logic idle;
    logic [3:0] run_index;
    logic new_segment;
    logic first_run;
    logic [23:0] response_time;
    logic finishes;
    logic [23:0] completion_time;
    logic [23:0] turnaround;
    logic [23:0] waiting;
    logic all_done;
  } lrts_res_t;
endpackage
`default_nettype wire

### sv/lrts_datapath.sv
// Slot tables, sequential max scan and tick update.
`default_nettype none
module lrts_datapath (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire lrts_pkg::lrts_cmd_t   cmd,
  output lrts_pkg::lrts_sts_t        sts,
  input  wire logic [3:0]            ld_slot,
  input  wire logic [15:0]           ld_arrival,
  input  wire logic [15:0]           ld_burst,
  input  wire logic [4:0]            proc_count,
  output lrts_pkg::lrts_res_t        res
);
  import lrts_pkg::*;

  logic [15:0] arr_r [PROCS];
  logic [15:0] bur_r [PROCS];
  logic [15:0] rem_r [PROCS];
  logic [PROCS-1:0] started_r, finished_r;
  logic [23:0] time_r;
  logic [CW-1:0] last_r;
  logic found_r;
  logic [SW-1:0] pick_r;
  logic [15:0] best_r;
  logic [PROCS-1:0] act;
  logic [4:0] n_eff;
  logic [23:0] end_t, tat;
  logic [15:0] bur_fix, rem_dec;
  logic [CW-1:0] runner;
  logic elig, fin_now;
  logic [PROCS-1:0] fin_after;
  lrts_res_t res_nxt;

  assign n_eff = (proc_count > 5'(PROCS)) ? 5'(PROCS) : proc_count;
  always_comb begin
    for (int i = 0; i < PROCS; i++) act[i] = (5'(i) < n_eff);
  end
  assign sts.all_fin = &(finished_r | ~act);
  assign bur_fix = (ld_burst == 16'd0) ? 16'd1 : ld_burst;
  assign elig = act[cmd.scan_idx] && ({8'd0, arr_r[cmd.scan_idx]} <= time_r)
                && !finished_r[cmd.scan_idx];
  assign end_t = (time_r < TIME_MAX) ? time_r + 24'd1 : TIME_MAX;
  assign rem_dec = (rem_r[pick_r] != 16'd0) ? rem_r[pick_r] - 16'd1 : 16'd0;
  assign fin_now = (rem_dec == 16'd0);
  assign tat = end_t - {8'd0, arr_r[pick_r]};
  assign runner = found_r ? {1'b0, pick_r} : CW'(PROCS);
  always_comb begin
    fin_after = finished_r;
    if (found_r && fin_now) fin_after[pick_r] = 1'b1;
  end

  always_comb begin
    res_nxt = '0;
    res_nxt.slot_start = time_r;
    if (sts.all_fin) begin
      res_nxt.idle = 1'b1;
      res_nxt.all_done = 1'b1;
    end else begin
      res_nxt.idle = !found_r;
      res_nxt.run_index = found_r ? 4'(pick_r) : 4'd0;
      res_nxt.new_segment = (runner != last_r);
      if (found_r && !started_r[pick_r]) begin
        res_nxt.first_run = 1'b1;
        res_nxt.response_time = time_r - {8'd0, arr_r[pick_r]};
      end
      if (found_r && fin_now) begin
        res_nxt.finishes = 1'b1;
        res_nxt.completion_time = end_t;
        res_nxt.turnaround = tat;
        res_nxt.waiting = (tat >= {8'd0, bur_r[pick_r]}) ?
                          tat - {8'd0, bur_r[pick_r]} : 24'd0;
      end
      res_nxt.all_done = &(fin_after | ~act);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      arr_r[ld_slot] <= ld_arrival;
      bur_r[ld_slot] <= bur_fix;
      rem_r[ld_slot] <= bur_fix;
    end else if (cmd.update && found_r) begin
      rem_r[pick_r] <= rem_dec;
    end
    if (cmd.scan_clr) begin
      found_r <= 1'b0;
      pick_r <= '0;
      best_r <= '0;
    end else if (cmd.scan_step && elig && (!found_r || rem_r[cmd.scan_idx] > best_r)) begin
      found_r <= 1'b1;
      pick_r <= cmd.scan_idx;
      best_r <= rem_r[cmd.scan_idx];
    end
    if (cmd.update) res <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      started_r <= '0;
      finished_r <= '0;
      time_r <= '0;
      last_r <= CW'(PROCS + 1);
    end else if (cmd.load) begin
      started_r[ld_slot] <= 1'b0;
      finished_r[ld_slot] <= 1'b0;
    end else if (cmd.update && !sts.all_fin) begin
      last_r <= runner;
      time_r <= end_t;
      finished_r <= fin_after;
      if (found_r) started_r[pick_r] <= 1'b1;
    end
  end
endmodule
`default_nettype wire

### sv/lrts_ctrl.sv
// Controller: accepts items, sequences the slot scan and the result hand-off.
`default_nettype none
module lrts_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_fire,
  input  wire logic                 in_cmd,
  output logic                      busy,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output lrts_pkg::lrts_cmd_t       cmd
);
  import lrts_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0, S_SCAN = 2'd1, S_UPD = 2'd2, S_OUT = 2'd3;
  logic [1:0] st_r, st_nxt;
  logic [SW-1:0] idx_r, idx_nxt;

  always_comb begin
    st_nxt = st_r;
    idx_nxt = idx_r;
    cmd = '0;
    cmd.scan_idx = idx_r;
    case (st_r)
      S_IDLE: begin
        if (in_fire && in_cmd == CMD_LOAD) cmd.load = 1'b1;
        if (in_fire && in_cmd == CMD_TICK) begin
          cmd.scan_clr = 1'b1;
          idx_nxt = '0;
          st_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        idx_nxt = idx_r + 1'b1;
        if (idx_r == SW'(PROCS - 1)) st_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        st_nxt = S_OUT;
      end
      S_OUT: if (out_tready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  assign busy = (st_r != S_IDLE);
  assign out_tvalid = (st_r == S_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      idx_r <= '0;
    end else begin
      st_r <= st_nxt;
      idx_r <= idx_nxt;
    end
  end
endmodule
`default_nettype wire

### sv/longest_remaining_time_scheduler.sv
// Top level of the longest-remaining-time-first scheduler.
//  channel | dir | transfer carries
//  in_     | in  | load (slot, arrival, burst) or tick
//  out_    | out | one result per tick
//  cfg_    | in  | proc_count write
// Load: writes one slot when accepted. Tick: accept, a scan of the 16 slots (one slot
// per cycle), an update, then an output state held until out_tready. in_tready is low while a
// tick is in work or its result waits. Reset clears marks, time and the count to 16.
`default_nettype none
module longest_remaining_time_scheduler (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // slot[3:0], arrival[19:4], burst[35:20], zero
  input  wire logic        in_tuser,   // cmd
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [135:0]     out_tdata,  // slot_start, idle, run_index, new_segment,
                                        // first_run, response_time, finishes,
                                        // completion_time, turnaround, waiting,
                                        // all_done, zero
  input  wire logic        cfg_we,
  input  wire logic [4:0]  cfg_wdata
);
  import lrts_pkg::*;

  lrts_cmd_t cmd;
  lrts_sts_t sts;
  lrts_res_t res;
  logic busy;
  logic [4:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= 5'd16;
    else if (cfg_we) count_r <= cfg_wdata;
  end

  assign in_tready = !busy;

  lrts_ctrl u_ctrl (
    .clk, .rst_n,
    .in_fire(in_tvalid && in_tready),
    .in_cmd(in_tuser),
    .busy,
    .out_tvalid,
    .out_tready,
    .cmd
  );

  lrts_datapath u_dp (
    .clk, .rst_n, .cmd, .sts,
    .ld_slot(in_tdata[3:0]),
    .ld_arrival(in_tdata[19:4]),
    .ld_burst(in_tdata[35:20]),
    .proc_count(count_r),
    .res
  );

  assign out_tdata = {7'd0, res.all_done, res.waiting, res.turnaround,
                      res.completion_time, res.finishes, res.response_time,
                      res.first_run, res.new_segment, res.run_index, res.idle,
                      res.slot_start};
endmodule
`default_nettype wire
